// ----- sv/kmrb_pkg.sv -----
// kmrb_pkg: shared types, codes and the layer code ROM for the keyboard matrix
// report builder. No dependencies.

package kmrb_pkg;

  localparam int ROW_W       = 2;
  localparam int COL_W       = 4;
  localparam int SLOT_W      = 5;
  localparam int NEXT_W      = 6;
  localparam int CODE_W      = 8;
  localparam int KEY_OUTS    = 6;
  localparam int FIRST_SLOT  = 2;
  localparam int MAX_SLOTS   = 8;   // boot report is 8 bytes
  localparam int ROM_ROWS    = 3;
  localparam int ROM_COLS    = 10;
  localparam int IN_DATA_W   = 8;
  localparam int OUT_DATA_W  = 64;
  localparam int OUT_LAYER_BIT = CODE_W * (KEY_OUTS + 1);

  typedef logic [SLOT_W-1:0] slot_t;
  typedef logic [NEXT_W-1:0] next_t;
  typedef logic [CODE_W-1:0] code_t;

  localparam next_t SLOT_BASE  = 6'd2;
  localparam next_t SLOT_LIMIT = 6'd31;

  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_SCAN   = 1'b1;
  localparam logic LAYER_MAIN  = 1'b0;
  localparam logic LAYER_GAME  = 1'b1;

  localparam code_t MOD_NONE       = 8'h00;
  localparam code_t MOD_LEFT_SHIFT = 8'h02;

  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] column;
    logic             pressed;
  } sample_t;

  typedef struct packed {
    logic                      layer;
    code_t [KEY_OUTS-1:0]      key_code;
    code_t                     modifier;
  } report_t;

  localparam code_t LAYER_ROM [2][ROM_ROWS][ROM_COLS] = '{
    '{
      '{8'h14, 8'h1a, 8'h08, 8'h15, 8'h17, 8'h1c, 8'h18, 8'h0c, 8'h12, 8'h13},
      '{8'h04, 8'h16, 8'h07, 8'h09, 8'h0a, 8'h0b, 8'h0d, 8'h0e, 8'h0f, 8'h00},
      '{8'h1d, 8'h1b, 8'h06, 8'h19, 8'h2c, 8'h05, 8'h11, 8'h10, 8'h00, 8'h28}
    },
    '{
      '{8'h29, 8'h00, 8'h14, 8'h1a, 8'h08, 8'h15, 8'h00, 8'h00, 8'h00, 8'h00},
      '{8'h00, 8'h00, 8'h04, 8'h16, 8'h07, 8'h09, 8'h0a, 8'h00, 8'h00, 8'h00},
      '{8'h00, 8'h00, 8'h00, 8'h00, 8'h2c, 8'h2c, 8'h00, 8'h00, 8'h00, 8'h28}
    }
  };

  // Code for a ROM position; anything outside the table reads as no key.
  function automatic code_t rom_code(input int layer, input int mr, input int mc);
    code_t res;
    res = MOD_NONE;
    if (mr >= 0 && mr < ROM_ROWS && mc >= 0 && mc < ROM_COLS) begin
      res = LAYER_ROM[layer][mr][mc];
    end
    return res;
  endfunction

endpackage

// ----- sv/kmrb_slot_table.sv -----
// kmrb_slot_table: per-key press-order slot registers and the next-slot counter.
// Depends on kmrb_pkg.

module kmrb_slot_table #(
  parameter int ROWS    = 3,
  parameter int COLUMNS = 10
) (
  input  logic                                          clk,
  input  logic                                          rst_n,
  input  logic                                          sample_en,
  input  kmrb_pkg::sample_t                             sample,
  output logic [ROWS*COLUMNS-1:0][kmrb_pkg::SLOT_W-1:0] slots
);
  import kmrb_pkg::*;

  localparam int NKEYS = ROWS * COLUMNS;

  logic [NKEYS-1:0][SLOT_W-1:0] slot_r, slot_nxt;
  next_t                        next_slot_r, next_slot_nxt;
  logic [NKEYS-1:0]             hit;
  slot_t                        gone;

  // one decoder per key; samples outside the matrix hit nothing
  for (genvar k = 0; k < NKEYS; k++) begin : g_hit
    localparam int KR = k / COLUMNS;
    localparam int KC = k % COLUMNS;
    assign hit[k] = ({2'b00, sample.row} == 4'(KR)) && (sample.column == 4'(KC));
  end

  // slot of the sampled key (hit is one-hot or empty)
  always_comb begin
    gone = '0;
    for (int k = 0; k < NKEYS; k++) begin
      if (hit[k]) begin
        gone = gone | slot_r[k];
      end
    end
  end

  always_comb begin
    slot_nxt      = slot_r;
    next_slot_nxt = next_slot_r;
    if (sample_en && (|hit)) begin
      if (sample.pressed) begin
        if (gone == '0 && next_slot_r <= SLOT_LIMIT) begin
          for (int k = 0; k < NKEYS; k++) begin
            if (hit[k]) begin
              slot_nxt[k] = next_slot_r[SLOT_W-1:0];
            end
          end
          next_slot_nxt = next_slot_r + 1'b1;
        end
      end else if (gone != '0) begin
        // release: close the gap above the freed slot
        for (int k = 0; k < NKEYS; k++) begin
          if (hit[k]) begin
            slot_nxt[k] = '0;
          end else if (slot_r[k] > gone) begin
            slot_nxt[k] = slot_r[k] - 1'b1;
          end
        end
        if (next_slot_r > SLOT_BASE) begin
          next_slot_nxt = next_slot_r - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r      <= '0;
      next_slot_r <= SLOT_BASE;
    end else begin
      slot_r      <= slot_nxt;
      next_slot_r <= next_slot_nxt;
    end
  end

  assign slots = slot_r;

endmodule

// ----- sv/kmrb_report.sv -----
// kmrb_report: layer decision and HID boot report assembly from the slot table.
// Depends on kmrb_pkg.

module kmrb_report #(
  parameter int ROWS         = 3,
  parameter int COLUMNS      = 10,
  parameter int REPORT_BYTES = 8
) (
  input  logic [ROWS*COLUMNS-1:0][kmrb_pkg::SLOT_W-1:0] slots,
  input  logic                                          layer,
  output kmrb_pkg::report_t                             rpt
);
  import kmrb_pkg::*;

  localparam int NKEYS = ROWS * COLUMNS;

  slot_t s01, s10, s20, s18, s19;
  logic  to_game, new_layer;
  logic [NKEYS-1:0][CODE_W-1:0]    code_k;
  logic [KEY_OUTS-1:0][CODE_W-1:0] pos_code;

  // named keys; a key that is not in the matrix reads as not held
  if (COLUMNS > 1) begin : g_s01
    assign s01 = slots[1];
  end else begin : g_no_s01
    assign s01 = '0;
  end
  if (ROWS > 1) begin : g_s10
    assign s10 = slots[COLUMNS];
  end else begin : g_no_s10
    assign s10 = '0;
  end
  if (ROWS > 2) begin : g_s20
    assign s20 = slots[2*COLUMNS];
  end else begin : g_no_s20
    assign s20 = '0;
  end
  if (ROWS > 1 && COLUMNS > 9) begin : g_shift
    assign s18 = slots[COLUMNS+8];
    assign s19 = slots[COLUMNS+9];
  end else begin : g_no_shift
    assign s18 = '0;
    assign s19 = '0;
  end

  assign to_game   = (layer == LAYER_MAIN) && (s01 != '0) && (s10 < s01);
  assign new_layer = to_game ? LAYER_GAME : ((s20 != '0) ? LAYER_MAIN : layer);

  // mirrored ROM lookup, fixed per key
  for (genvar k = 0; k < NKEYS; k++) begin : g_code
    localparam int    MR        = ROWS - 1 - k / COLUMNS;
    localparam int    MC        = COLUMNS - 1 - k % COLUMNS;
    localparam code_t CODE_MAIN = rom_code(int'(LAYER_MAIN), MR, MC);
    localparam code_t CODE_GAME = rom_code(int'(LAYER_GAME), MR, MC);
    assign code_k[k] = (new_layer == LAYER_GAME) ? CODE_GAME : CODE_MAIN;
  end

  // held slots are unique, so OR-ing the matches picks the single key
  always_comb begin
    pos_code = '0;
    for (int p = 0; p < KEY_OUTS; p++) begin
      if (p + FIRST_SLOT < REPORT_BYTES && p + FIRST_SLOT < MAX_SLOTS) begin
        for (int k = 0; k < NKEYS; k++) begin
          if (slots[k] == SLOT_W'(p + FIRST_SLOT)) begin
            pos_code[p] = pos_code[p] | code_k[k];
          end
        end
      end
    end
  end

  assign rpt.layer    = new_layer;
  assign rpt.key_code = pos_code;
  assign rpt.modifier = (new_layer == LAYER_GAME && s18 != '0 && s19 != '0) ?
                        MOD_LEFT_SHIFT : MOD_NONE;

endmodule

// ----- sv/keyboard_matrix_report_builder_unit.sv -----
// keyboard_matrix_report_builder_unit: top level; input word register, layer
// register and result register around kmrb_slot_table and kmrb_report (kmrb_pkg).

// Takes one word per clock. A key-sample word (tuser 0) updates the
// press-order slot table and produces nothing; an end-of-scan word (tuser 1)
// updates the layer and produces one report word. Each word sits in the
// input register while the slot table or the report logic works on it; a
// report word is then registered in the result register and shows on out_*.
// in_tready stays high every cycle except when an end-of-scan word is parked in
// the input register behind a report the sink has not yet taken; key samples
// never wait on the output side. Sustained rate: one word per cycle.
// Slot and layer state reset to "no key held", main layer.

module keyboard_matrix_report_builder_unit #(
  parameter int ROWS         = 3,
  parameter int COLUMNS      = 10,
  parameter int REPORT_BYTES = 8
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // input word
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [kmrb_pkg::IN_DATA_W-1:0]      in_tdata,  // row[1:0], column[5:2], pressed[6]
  input  logic                                in_tuser,  // kind: 0 key sample, 1 end of scan
  // report word
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [kmrb_pkg::OUT_DATA_W-1:0]     out_tdata  // modifier_byte[7:0],
                                                         // key_code_0..5[55:8],
                                                         // layer_in_use[56]
);
  import kmrb_pkg::*;

  localparam int NKEYS = ROWS * COLUMNS;

  // input register
  logic    in_valid_r, in_valid_nxt;
  logic    in_kind_r;
  sample_t in_sample_r;

  // work stage
  logic    out_free, fire, in_fire, sample_en, scan_fire;
  logic [NKEYS-1:0][SLOT_W-1:0] slots;
  report_t rpt;

  // state and result register
  logic    layer_r;
  logic    out_valid_r, out_valid_nxt;
  report_t out_rpt_r;

  assign in_fire   = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;
  // samples retire without the output; a scan needs room for its report
  assign fire      = in_valid_r && (in_kind_r == KIND_SAMPLE || out_free);
  assign in_tready = !in_valid_r || fire;
  assign sample_en = fire && (in_kind_r == KIND_SAMPLE);
  assign scan_fire = fire && (in_kind_r == KIND_SCAN);

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (in_fire) begin
      in_valid_nxt = 1'b1;
    end else if (fire) begin
      in_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (scan_fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      layer_r     <= LAYER_MAIN;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (scan_fire) begin
        layer_r <= rpt.layer;
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (in_fire) begin
      in_kind_r          <= in_tuser;
      in_sample_r.row    <= in_tdata[1:0];
      in_sample_r.column <= in_tdata[5:2];
      in_sample_r.pressed <= in_tdata[6];
    end
    if (scan_fire) begin
      out_rpt_r <= rpt;
    end
  end

  kmrb_slot_table #(
    .ROWS    (ROWS),
    .COLUMNS (COLUMNS)
  ) u_slot_table (
    .clk       (clk),
    .rst_n     (rst_n),
    .sample_en (sample_en),
    .sample    (in_sample_r),
    .slots     (slots)
  );

  kmrb_report #(
    .ROWS         (ROWS),
    .COLUMNS      (COLUMNS),
    .REPORT_BYTES (REPORT_BYTES)
  ) u_report (
    .slots (slots),
    .layer (layer_r),
    .rpt   (rpt)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_DATA_W-OUT_LAYER_BIT-1){1'b0}}, out_rpt_r.layer,
                       out_rpt_r.key_code, out_rpt_r.modifier};

endmodule

// ----- sv/kmrb_checker.sv -----
// kmrb_checker: port-level assertions for keyboard_matrix_report_builder_unit,
// bound to the top level below. Depends on kmrb_pkg.

module kmrb_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tready,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [kmrb_pkg::OUT_DATA_W-1:0] out_tdata
);
  import kmrb_pkg::*;

  // a stalled report word stays put
  a_out_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("report word dropped while stalled");

  a_out_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata))
    else $error("report word changed while stalled");

  // input only backs up behind a pending report
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid)
    else $error("input stalled with empty output register");

  // shift only in the game layer
  a_shift_game: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[CODE_W-1:0] != MOD_NONE |->
      out_tdata[CODE_W-1:0] == MOD_LEFT_SHIFT && out_tdata[OUT_LAYER_BIT] == LAYER_GAME)
    else $error("modifier outside game layer or bad modifier code");

endmodule

bind keyboard_matrix_report_builder_unit kmrb_checker u_kmrb_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
